### hdl/ust_pkg.sv
// Package: shared constants, types and codes of the usage statistics table.
`default_nettype none

package ust_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int ID_W        = 20;
    localparam int NUM_TYPES   = 3;
    localparam int TYPE_W      = 2;
    localparam int OP_W        = 2;

    // Field widths
    localparam int TIME_W  = 32;
    localparam int COUNT_W = 31;
    localparam int TS_W    = 64;

    // Divide by 1000 as (x >> 3) / 125, the latter by reciprocal multiply.
    // Below the seconds ceiling x >> 3 fits Y_W bits; the product is built
    // from four PART_W x PART_W partial products.
    localparam int DIVISOR  = 1000;
    localparam int Y_LSB    = 3;
    localparam int Y_W      = 39;
    localparam int PART_W   = 20;
    localparam int PP_W     = 2 * PART_W;
    localparam int PROD_W   = 4 * PART_W;
    localparam int RECIP_SH = 46;
    // ceil(2^46 / 125)
    localparam logic [PP_W-1:0] RECIP_125 = 40'd562949953422;
    localparam logic [PP_W-1:0] RECIP_LO  = {{(PP_W-PART_W){1'b0}}, RECIP_125[PART_W-1:0]};
    localparam logic [PP_W-1:0] RECIP_HI  = {{(PP_W-PART_W){1'b0}}, RECIP_125[PP_W-1:PART_W]};
    // first millisecond value whose seconds no longer fit TIME_W bits
    localparam logic [TS_W-1:0] SAT_MS    = TS_W'(DIVISOR) << TIME_W;

    // Stream layout
    localparam int IN_ID_LSB    = 0;
    localparam int IN_TYPE_LSB  = IN_ID_LSB + ID_W;
    localparam int IN_TS_LSB    = IN_TYPE_LSB + TYPE_W;
    localparam int IN_TIME_LSB  = IN_TS_LSB + TS_W;
    localparam int IN_COUNT_LSB = IN_TIME_LSB + NUM_TYPES * TIME_W;
    localparam int IN_USED_W    = IN_COUNT_LSB + NUM_TYPES * COUNT_W;
    localparam int IN_DATA_W    = ((IN_USED_W + 7) / 8) * 8;

    localparam int REC_W      = NUM_TYPES * (TIME_W + COUNT_W);
    localparam int OUT_DATA_W = ((REC_W + 7) / 8) * 8;

    localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // One record: times in the low bits, counts above, type 0 lowest
    typedef struct packed {
        logic [NUM_TYPES-1:0][COUNT_W-1:0] counts;
        logic [NUM_TYPES-1:0][TIME_W-1:0]  times;
    } rec_t;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_DELETE = 2'd1,
        OP_GET    = 2'd2,
        OP_SET    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_RESULT
    } state_t;

endpackage

`default_nettype wire

### hdl/ust_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
`default_nettype none

module ust_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic                                      re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rd_data_reg;

endmodule

`default_nettype wire

### hdl/ust_div1000.sv
// Divide by 1000 through a reciprocal multiply, two register stages after the load.
`default_nettype none

module ust_div1000 (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [ust_pkg::TS_W-1:0]   dividend,
    output logic                            done,
    output logic                            sat,
    output logic      [ust_pkg::TIME_W-1:0] quotient
);
    import ust_pkg::*;

    logic              s1_reg;
    logic              s2_reg;
    logic              done_reg;
    logic              sat_reg;
    logic [Y_W-1:0]    y_reg;
    logic [PP_W-1:0]   pp_ll_reg;
    logic [PP_W-1:0]   pp_lh_reg;
    logic [PP_W-1:0]   pp_hl_reg;
    logic [PP_W-1:0]   pp_hh_reg;
    logic [TIME_W-1:0] quo_reg;
    logic [PP_W-1:0]   y_lo;
    logic [PP_W-1:0]   y_hi;
    logic [PROD_W-1:0] prod;

    // halves of x >> 3, zero-extended; each partial product is at most 20 x 20 bits
    assign y_lo = {{(PP_W-PART_W){1'b0}}, y_reg[PART_W-1:0]};
    assign y_hi = {{(PP_W-(Y_W-PART_W)){1'b0}}, y_reg[Y_W-1:PART_W]};

    assign prod = {pp_hh_reg, {PP_W{1'b0}}}
                + {{(PROD_W-PP_W-PART_W){1'b0}}, pp_lh_reg, {PART_W{1'b0}}}
                + {{(PROD_W-PP_W-PART_W){1'b0}}, pp_hl_reg, {PART_W{1'b0}}}
                + {{PP_W{1'b0}}, pp_ll_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg    <= 1'b0;
            s2_reg    <= 1'b0;
            done_reg  <= 1'b0;
            sat_reg   <= 1'b0;
            y_reg     <= '0;
            pp_ll_reg <= '0;
            pp_lh_reg <= '0;
            pp_hl_reg <= '0;
            pp_hh_reg <= '0;
            quo_reg   <= '0;
        end
        else
        begin
            s1_reg <= start;
            s2_reg <= s1_reg;
            if (start)
            begin
                sat_reg <= dividend >= SAT_MS;
                y_reg   <= dividend[Y_LSB +: Y_W];
            end
            if (s1_reg)
            begin
                pp_ll_reg <= y_lo * RECIP_LO;
                pp_lh_reg <= y_lo * RECIP_HI;
                pp_hl_reg <= y_hi * RECIP_LO;
                pp_hh_reg <= y_hi * RECIP_HI;
            end
            if (s2_reg)
            begin
                quo_reg <= prod[RECIP_SH +: TIME_W];
            end
            if (start)
            begin
                done_reg <= 1'b0;
            end
            else if (s2_reg)
            begin
                done_reg <= 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign sat      = sat_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

### hdl/usage_statistics_table_unit.sv
// Top level: usage statistics table, one record RAM with read-modify-write sequencer.
// Sequence: the RAM read starts as the beat is taken, ST_READ registers the record,
//   an add-report waits in ST_DIV for the divide by 1000, then ST_RESULT writes back.
// Flow: one item at a time; s_axis_tready stays low until ST_RESULT has loaded the
//   output register, which waits while a held result is not taken on m_axis.
// Reset: asynchronous; afterwards a clearing pass zeroes every record while
//   s_axis_tready stays low.
`default_nettype none

module usage_statistics_table_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // s_axis_tdata, from bit 0: doc_id, kind, timestamp_ms,
    //   set_time_a, set_time_b, set_time_c, set_count_a, set_count_b, set_count_c, zero pad
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [ust_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // s_axis_tuser: operation
    input  wire logic [ust_pkg::OP_W-1:0]       s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // m_axis_tdata, from bit 0: time_a, time_b, time_c, count_a, count_b, count_c, zero pad
    output logic      [ust_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // m_axis_tuser: status (1 = invalid document id)
    output logic                                m_axis_tuser
);
    import ust_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Sweep address for the post-reset clear
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              clr_last;

    // Item held for the duration of its read-modify-write
    op_t               op_reg;
    logic              id_ok_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [TYPE_W-1:0] type_reg;
    logic              ts_neg_reg;
    rec_t              set_rec_reg;
    rec_t              rec_reg;

    // Output register, parts the result from the input side
    logic                  m_valid_reg;
    logic [OUT_DATA_W-1:0] m_data_reg;
    logic                  m_user_reg;

    logic              in_beat;
    logic              in_id_ok;
    op_t               in_op;
    logic              out_free;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    rec_t              ram_wdata;
    rec_t              ram_rdata;
    logic              out_load;

    logic              div_start;
    logic              div_done;
    logic              div_sat;
    logic [TIME_W-1:0] quotient;

    rec_t              new_rec;

    assign in_op    = op_t'(s_axis_tuser);
    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign in_id_ok = {1'b0, s_axis_tdata[IN_ID_LSB +: ID_W]} < (ID_W+1)'(TABLE_DEPTH);
    assign out_free = !m_valid_reg || m_axis_tready;
    assign clr_last = clr_addr_reg == ADDR_W'(TABLE_DEPTH - 1);

    // Only a valid add-report needs the seconds value
    assign div_start = in_beat && (in_op == OP_ADD) && in_id_ok;

    ust_ram #(
        .WIDTH (REC_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_beat),
        .raddr (s_axis_tdata[IN_ID_LSB +: ADDR_W]),
        .rdata (ram_rdata)
    );

    ust_div1000 u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({1'b0, s_axis_tdata[IN_TS_LSB +: TS_W-1]}),
        .done     (div_done),
        .sat      (div_sat),
        .quotient (quotient)
    );

    // Record after the operation
    always_comb
    begin
        new_rec = rec_reg;
        case (op_reg)
            OP_ADD:
            begin
                // usage type three matches no slot and leaves the record alone
                for (int k = 0; k < NUM_TYPES; k++)
                begin
                    if (type_reg == TYPE_W'(k))
                    begin
                        if (!ts_neg_reg)
                        begin
                            if (div_sat)
                            begin
                                new_rec.times[k] = TIME_MAX;
                            end
                            else if (quotient > rec_reg.times[k])
                            begin
                                new_rec.times[k] = quotient;
                            end
                        end
                        if (rec_reg.counts[k] != COUNT_MAX)
                        begin
                            new_rec.counts[k] = rec_reg.counts[k] + 1'b1;
                        end
                    end
                end
            end
            OP_DELETE: new_rec = '0;
            OP_GET:    new_rec = rec_reg;
            OP_SET:    new_rec = set_rec_reg;
            default:   new_rec = rec_reg;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if ((op_reg == OP_ADD) && id_ok_reg)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = addr_reg;
        ram_wdata     = new_rec;
        out_load      = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
            end
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            ST_RESULT:
            begin
                out_load = out_free;
                ram_we   = out_free && id_ok_reg;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            op_reg      <= in_op;
            id_ok_reg   <= in_id_ok;
            addr_reg    <= s_axis_tdata[IN_ID_LSB +: ADDR_W];
            type_reg    <= s_axis_tdata[IN_TYPE_LSB +: TYPE_W];
            ts_neg_reg  <= s_axis_tdata[IN_TS_LSB + TS_W - 1];
            set_rec_reg <= rec_t'(s_axis_tdata[IN_TIME_LSB +: REC_W]);
        end
        if (state_reg == ST_READ)
        begin
            rec_reg <= ram_rdata;
        end
        if (out_load)
        begin
            // an invalid id answers with all fields zero
            m_data_reg <= id_ok_reg ? OUT_DATA_W'(new_rec) : '0;
            m_user_reg <= !id_ok_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

`default_nettype wire

### hdl/ust_checker.sv
// Port-level checker for the usage statistics table, bound to the top level.
`default_nettype none

module ust_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    input  wire logic                           s_axis_tready,
    input  wire logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    input  wire logic [ust_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  wire logic                           m_axis_tuser
);

    // a result beat held back stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat withdrawn while stalled");

    // and keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result payload changed");

    // invalid id answers with an empty record
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("invalid-id result carries data");

    // one item in flight: no beat is taken straight after another
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in flight");

endmodule

bind usage_statistics_table_unit ust_checker u_ust_checker (.*);

`default_nettype wire
